// File: design/sampled_curve_interp_integrate_defines.svh
// Assertion macros for the sampled curve block.
// Taken in by the checker module; depends on nothing else.
`ifndef SAMPLED_CURVE_INTERP_INTEGRATE_DEFINES_SVH
`define SAMPLED_CURVE_INTERP_INTEGRATE_DEFINES_SVH

// antecedent holds -> consequent holds in the same cycle
`define SCIT_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("scit check failed");

// antecedent holds -> consequent holds in the next cycle
`define SCIT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("scit check failed");

`endif

// File: design/scit_pkg.sv
// Shared constants for the sampled curve interpolate/integrate block.
// No dependencies; imported by every module of the block.
`default_nettype none
package scit_pkg;
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = 10;
   localparam int CNT_W       = 11;
   localparam int FRAC_BITS   = 16;
   localparam int OP_W        = 33;
   localparam int PROD_W      = 66;
   localparam int ACC_W       = 80;

   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_INTERP = 2'd1;
   localparam logic [1:0] CMD_INTEG  = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FEW   = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;
endpackage
`default_nettype wire

// File: design/sampled_curve_interp_integrate.sv
// Interpolate: range check, binary search by halving, fetch of the bracketing pair,
// multiply, then divide. Write and unused commands go straight to the result.
// Integrate: two interpolations, then a read and check of each table point in use,
// plus a multiply per point strictly inside the bounds and one for the closing segment.
// One request at a time; a result waits in its output register while the next is taken.
// Synchronous reset clears the sequencer and point count; the table has no reset value.
`default_nettype none
module sampled_curve_interp_integrate
   import scit_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [9:0]         req_point_index,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_query_x,
   input  wire logic signed [31:0] req_bound_low,
   input  wire logic signed [31:0] req_bound_high,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [63:0]      rsp_value,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [10:0]        csr_point_count
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LO    = 4'd1;
   localparam logic [3:0] S_HI    = 4'd2;
   localparam logic [3:0] S_SSET  = 4'd3;
   localparam logic [3:0] S_SCMP  = 4'd4;
   localparam logic [3:0] S_PAIR0 = 4'd5;
   localparam logic [3:0] S_PAIR1 = 4'd6;
   localparam logic [3:0] S_PAIR2 = 4'd7;
   localparam logic [3:0] S_MULI  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_IRES  = 4'd10;
   localparam logic [3:0] S_WRD   = 4'd11;
   localparam logic [3:0] S_WCHK  = 4'd12;
   localparam logic [3:0] S_WMUL  = 4'd13;
   localparam logic [3:0] S_WEND  = 4'd14;
   localparam logic [3:0] S_FIN   = 4'd15;

   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;
   localparam int SHIFT = FRAC_BITS + 1;

   // control
   logic [3:0]        state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  count_ff;
   // payload
   logic [1:0]               cmd_ff, cmd_in;
   logic signed [31:0]       q_ff, q_in, a_ff, a_in, b_ff, b_in;
   logic                     flip_ff, flip_in, phase_ff, phase_in;
   logic [CNT_W-1:0]         below_ff, below_in, above_ff, above_in, mid_ff, mid_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic signed [31:0]       xlo_ff, xlo_in, x0_ff, x0_in, y0_ff, y0_in;
   logic [OP_W-1:0]          dxmag_ff, dxmag_in;
   logic                     dneg_ff, dneg_in;
   logic signed [63:0]       ires_ff, ires_in;
   logic signed [31:0]       fa_ff, fa_in, fb_ff, fb_in, px_ff, px_in, py_ff, py_in;
   logic [CNT_W-1:0]         i_ff, i_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic                     psign_ff, psign_in, last_ff, last_in;
   logic signed [63:0]       res_value_ff, res_value_in, rsp_value_ff, rsp_value_in;
   logic [1:0]               res_status_ff, res_status_in, rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]   n;
   logic [CNT_W:0]     mid_sum;
   logic [CNT_W-1:0]   mid_calc;
   logic [ADDR_W-1:0]  rd_addr, idx_clamp;
   logic [31:0]        rd_x_raw, rd_y_raw;
   logic signed [31:0] rd_x, rd_y;
   logic               mem_we;
   logic               mul_start, mul_done, div_start, div_done;
   logic [OP_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]  mul_prod, div_quo;
   logic               req_acc;

   logic signed [OP_W-1:0]    dx, dy, dt, s1, s2;
   logic signed [PROD_W+1:0]  sq;
   logic signed [PROD_W+2:0]  isum;
   logic signed [63:0]        isat;
   logic signed [31:0]        iclamp;
   logic signed [ACC_W-1:0]   pext, amag;
   logic [ACC_W-1:0]          ash;
   logic signed [63:0]        wval;
   logic                      lo_oor, a_oor, b_oor, q_oor;

   assign n         = (count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : count_ff;
   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign mem_we    = req_acc && (req_cmd == CMD_WRITE);
   assign rd_x      = rd_x_raw;
   assign rd_y      = rd_y_raw;

   // one extra bit: above + below reaches 2048 on a full table
   assign mid_sum  = {1'b0, above_ff} + {1'b0, below_ff};
   assign mid_calc = mid_sum[CNT_W:1];

   scit_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (req_point_index),
      .wr_x    (req_point_x),
      .wr_y    (req_point_y),
      .rd_addr (rd_addr),
      .rd_x    (rd_x_raw),
      .rd_y    (rd_y_raw)
   );

   scit_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   scit_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mul_prod),
      .den   (dxmag_ff),
      .quo   (div_quo),
      .done  (div_done)
   );

   assign idx_clamp = (CNT_W'(idx_ff) > (n - CNT_W'(2))) ? ADDR_W'(n - CNT_W'(2)) : idx_ff;

   always_comb begin
      case (state_ff)
         S_LO:    rd_addr = ADDR_W'(n - CNT_W'(1));
         S_SSET:  rd_addr = ADDR_W'(mid_calc - CNT_W'(1));
         S_PAIR0: rd_addr = idx_clamp;
         S_PAIR1: rd_addr = idx_ff + ADDR_W'(1);
         S_WRD:   rd_addr = i_ff[ADDR_W-1:0];
         default: rd_addr = '0;
      endcase
   end

   // arithmetic shared by several states
   always_comb begin
      dx = {rd_x[31], rd_x} - {x0_ff[31], x0_ff};
      dy = {rd_y[31], rd_y} - {y0_ff[31], y0_ff};
      dt = {q_ff[31], q_ff} - {x0_ff[31], x0_ff};
      sq = dneg_ff ? -$signed({2'b00, div_quo}) : $signed({2'b00, div_quo});
      isum = $signed({{(PROD_W-29){y0_ff[31]}}, y0_ff}) + $signed({sq[PROD_W+1], sq});
      if (isum[PROD_W+2:63] == '0 || isum[PROD_W+2:63] == '1) begin
         isat = isum[63:0];
      end else begin
         isat = isum[PROD_W+2] ? MIN64 : MAX64;
      end
      if (ires_ff > 64'sd2147483647) begin
         iclamp = 32'sh7FFF_FFFF;
      end else if (ires_ff < -64'sd2147483648) begin
         iclamp = 32'sh8000_0000;
      end else begin
         iclamp = ires_ff[31:0];
      end
      if (state_ff == S_WRD) begin
         s1 = {py_ff[31], py_ff} + {fb_ff[31], fb_ff};
         s2 = {b_ff[31], b_ff} - {px_ff[31], px_ff};
      end else begin
         s1 = {py_ff[31], py_ff} + {rd_y[31], rd_y};
         s2 = {rd_x[31], rd_x} - {px_ff[31], px_ff};
      end
      pext = psign_ff ? -$signed({{(ACC_W-PROD_W){1'b0}}, mul_prod})
                      : $signed({{(ACC_W-PROD_W){1'b0}}, mul_prod});
      amag = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
      ash  = amag >> SHIFT;
      wval = (acc_ff[ACC_W-1] != flip_ff) ? -$signed({1'b0, ash[62:0]})
                                          : $signed({1'b0, ash[62:0]});
      lo_oor = 1'b0;
      q_oor  = (q_ff < xlo_ff) || (q_ff > rd_x);
      a_oor  = (a_ff < xlo_ff) || (a_ff > rd_x);
      b_oor  = (b_ff < xlo_ff) || (b_ff > rd_x);
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      q_in          = q_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      flip_in       = flip_ff;
      phase_in      = phase_ff;
      below_in      = below_ff;
      above_in      = above_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      xlo_in        = xlo_ff;
      x0_in         = x0_ff;
      y0_in         = y0_ff;
      dxmag_in      = dxmag_ff;
      dneg_in       = dneg_ff;
      ires_in       = ires_ff;
      fa_in         = fa_ff;
      fb_in         = fb_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      i_in          = i_ff;
      acc_in        = acc_ff;
      psign_in      = psign_ff;
      last_in       = last_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      mul_start     = 1'b0;
      mul_a         = s1[32] ? OP_W'(-s1) : s1;
      mul_b         = s2[32] ? OP_W'(-s2) : s2;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               cmd_in        = req_cmd;
               q_in          = req_query_x;
               a_in          = req_bound_low;
               b_in          = req_bound_high;
               res_value_in  = '0;
               res_status_in = STAT_OK;
               if (req_cmd == CMD_INTERP || req_cmd == CMD_INTEG) begin
                  if (n < CNT_W'(2)) begin
                     res_status_in = STAT_FEW;
                     state_in      = S_FIN;
                  end else begin
                     state_in = S_LO;
                  end
               end else begin
                  state_in = S_FIN;
               end
            end
         end
         S_LO: begin
            xlo_in   = rd_x;
            state_in = S_HI;
         end
         S_HI: begin
            // rd_x now holds the last point in use
            below_in = '0;
            above_in = n + CNT_W'(1);
            phase_in = 1'b0;
            if (cmd_ff == CMD_INTERP) begin
               if (q_oor) begin
                  res_status_in = STAT_RANGE;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_SSET;
               end
            end else if (a_oor || b_oor || lo_oor) begin
               res_status_in = STAT_RANGE;
               state_in      = S_FIN;
            end else if (a_ff == b_ff) begin
               state_in = S_FIN;
            end else begin
               flip_in = a_ff > b_ff;
               if (a_ff > b_ff) begin
                  a_in = b_ff;
                  b_in = a_ff;
                  q_in = b_ff;
               end else begin
                  q_in = a_ff;
               end
               state_in = S_SSET;
            end
         end
         S_SSET: begin
            if (above_ff - below_ff > CNT_W'(1)) begin
               mid_in   = mid_calc;
               state_in = S_SCMP;
            end else begin
               idx_in   = (below_ff == '0) ? '0 : ADDR_W'(below_ff - CNT_W'(1));
               state_in = S_PAIR0;
            end
         end
         S_SCMP: begin
            if (q_ff == rd_x) begin
               idx_in   = ADDR_W'(mid_ff - CNT_W'(1));
               state_in = S_PAIR0;
            end else begin
               if (q_ff < rd_x) begin
                  above_in = mid_ff;
               end else begin
                  below_in = mid_ff;
               end
               state_in = S_SSET;
            end
         end
         S_PAIR0: begin
            idx_in   = idx_clamp;
            state_in = S_PAIR1;
         end
         S_PAIR1: begin
            x0_in    = rd_x;
            y0_in    = rd_y;
            state_in = S_PAIR2;
         end
         S_PAIR2: begin
            if (dx == '0) begin
               ires_in  = 64'(y0_ff);
               state_in = S_IRES;
            end else begin
               dxmag_in  = dx[32] ? OP_W'(-dx) : dx;
               dneg_in   = (dy[32] != dt[32]) != dx[32];
               mul_a     = dy[32] ? OP_W'(-dy) : dy;
               mul_b     = dt[32] ? OP_W'(-dt) : dt;
               mul_start = 1'b1;
               state_in  = S_MULI;
            end
         end
         S_MULI: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               ires_in  = isat;
               state_in = S_IRES;
            end
         end
         S_IRES: begin
            if (cmd_ff == CMD_INTERP) begin
               res_value_in = ires_ff;
               state_in     = S_FIN;
            end else if (!phase_ff) begin
               fa_in    = iclamp;
               q_in     = b_ff;
               phase_in = 1'b1;
               below_in = '0;
               above_in = n + CNT_W'(1);
               state_in = S_SSET;
            end else begin
               fb_in    = iclamp;
               px_in    = a_ff;
               py_in    = fa_ff;
               i_in     = '0;
               acc_in   = '0;
               last_in  = 1'b0;
               state_in = S_WRD;
            end
         end
         S_WRD: begin
            if (i_ff < n) begin
               state_in = S_WCHK;
            end else begin
               // closing segment up to the upper bound
               mul_start = 1'b1;
               psign_in  = s1[32] != s2[32];
               last_in   = 1'b1;
               state_in  = S_WMUL;
            end
         end
         S_WCHK: begin
            i_in = i_ff + CNT_W'(1);
            if (a_ff < rd_x && rd_x < b_ff) begin
               mul_start = 1'b1;
               psign_in  = s1[32] != s2[32];
               px_in     = rd_x;
               py_in     = rd_y;
               state_in  = S_WMUL;
            end else begin
               state_in = S_WRD;
            end
         end
         S_WMUL: begin
            if (mul_done) begin
               acc_in   = acc_ff + pext;
               state_in = last_ff ? S_WEND : S_WRD;
            end
         end
         S_WEND: begin
            res_value_in = wval;
            state_in     = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_point_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      q_ff          <= q_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      flip_ff       <= flip_in;
      phase_ff      <= phase_in;
      below_ff      <= below_in;
      above_ff      <= above_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      xlo_ff        <= xlo_in;
      x0_ff         <= x0_in;
      y0_ff         <= y0_in;
      dxmag_ff      <= dxmag_in;
      dneg_ff       <= dneg_in;
      ires_ff       <= ires_in;
      fa_ff         <= fa_in;
      fb_ff         <= fb_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      i_ff          <= i_in;
      acc_ff        <= acc_in;
      psign_ff      <= psign_in;
      last_ff       <= last_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
endmodule
`default_nettype wire

// File: design/scit_mem.sv
// Point table: x and y arrays, one write port, one registered read port.
// Depends on scit_pkg.
`default_nettype none
module scit_mem
   import scit_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_x,
   input  wire logic [31:0]       wr_y,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]            rd_x,
   output logic [31:0]            rd_y
);
   logic [31:0] x_mem [TABLE_DEPTH];
   logic [31:0] y_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
   end

   always_ff @(posedge clock) begin
      rd_x <= x_mem[rd_addr];
      rd_y <= y_mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: design/scit_mul.sv
// Unsigned 33x33 multiplier, one 17x17 partial product per cycle.
// Depends on scit_pkg.
`default_nettype none
module scit_mul
   import scit_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [OP_W-1:0]   a,
   input  wire logic [OP_W-1:0]   b,
   output logic [PROD_W-1:0]      prod,
   output logic                   done
);
   logic [OP_W-1:0]   a_ff, b_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [1:0]        step_ff;
   logic              busy_ff, done_ff;
   logic [16:0]       op_x, op_y;
   logic [33:0]       pp;
   logic [PROD_W-1:0] pp_sh;

   always_comb begin
      op_x = step_ff[1] ? {1'b0, a_ff[32:17]} : a_ff[16:0];
      op_y = step_ff[0] ? {1'b0, b_ff[32:17]} : b_ff[16:0];
      pp   = op_x * op_y;
      case (step_ff)
         2'd0:    pp_sh = {32'd0, pp};
         2'd1:    pp_sh = {15'd0, pp, 17'd0};
         2'd2:    pp_sh = {15'd0, pp, 17'd0};
         default: pp_sh = {pp[31:0], 34'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= 2'd0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + pp_sh;
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// File: design/scit_div.sv
// Restoring divider, 66-bit dividend by 33-bit divisor, one quotient bit a cycle.
// Depends on scit_pkg.
`default_nettype none
module scit_div
   import scit_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] num,
   input  wire logic [OP_W-1:0]   den,
   output logic [PROD_W-1:0]      quo,
   output logic                   done
);
   localparam int STEP_W = $clog2(PROD_W);

   logic [PROD_W-1:0] num_ff;
   logic [OP_W-1:0]   rem_ff, den_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [OP_W:0]     rem_sh;
   logic              ge;
   logic [OP_W:0]     diff;

   always_comb begin
      rem_sh = {rem_ff, num_ff[PROD_W-1]};
      ge     = rem_sh >= {1'b0, den_ff};
      diff   = rem_sh - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(PROD_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[PROD_W-2:0], ge};
         rem_ff <= ge ? diff[OP_W-1:0] : rem_sh[OP_W-1:0];
      end
   end

   assign quo  = num_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

// File: design/scit_checker.sv
// Port-level checks for sampled_curve_interp_integrate, attached by bind.
// Depends on scit_pkg and the assertion macro header.
`default_nettype none
`include "sampled_curve_interp_integrate_defines.svh"
module scit_checker
   import scit_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_value,
   input wire logic [1:0]  rsp_status
);
   `SCIT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SCIT_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, rsp_status != 2'd3)
   `SCIT_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_status != STAT_OK, rsp_value == '0)
   `SCIT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind sampled_curve_interp_integrate scit_checker u_scit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_value  (rsp_value),
   .rsp_status (rsp_status)
);
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for sampled_curve_interp_integrate: table writes, interpolation
// and trapezoid integration, checked against a predictor built into the bench.
// Depends on design/scit_pkg.sv and the block's RTL.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import scit_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;   // unused command, answered with zero
   localparam int ONE = 65536;                // 1.0 in Q16.16
   localparam longint RUN_LIMIT = 5_000_000;
   localparam longint VAL_MAX = 64'sh7fff_ffff_ffff_ffff;
   localparam longint VAL_MIN = 64'sh8000_0000_0000_0000;

   typedef logic signed [127:0] wide_type;

   typedef struct packed {
      logic                is_cfg;
      logic [10:0]         count;
      logic [1:0]          cmd;
      logic [9:0]          idx;
      logic signed [31:0]  px;
      logic signed [31:0]  py;
      logic signed [31:0]  qx;
      logic signed [31:0]  bl;
      logic signed [31:0]  bh;
      logic                fixed;   // expected result typed in below
      logic signed [63:0]  value;
      logic [1:0]          status;
   } step_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic [1:0]         status;
   } result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [1:0] req_cmd = CMD_WRITE;
   logic [9:0] req_point_index = '0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_query_x = '0;
   logic signed [31:0] req_bound_low = '0, req_bound_high = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [63:0] rsp_value;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [10:0] csr_point_count = '0;

   sampled_curve_interp_integrate dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_cmd, .req_point_index, .req_point_x, .req_point_y,
      .req_query_x, .req_bound_low, .req_bound_high,
      .rsp_valid, .rsp_ready, .rsp_value, .rsp_status,
      .csr_valid, .csr_ready, .csr_point_count
   );

   always #5 clock = ~clock;

   // curve state as the bench sees it
   int xtab [TABLE_DEPTH];
   int ytab [TABLE_DEPTH];
   logic [10:0] point_count = '0;

   result_type pending_results[$];
   int errors = 0;
   int sent_count = 0;
   int checked_count = 0;
   int burst_left = 0;
   longint cycles = 0;

   function automatic longint sat64(wide_type a);
      if (a > wide_type'(VAL_MAX)) return VAL_MAX;
      if (a < wide_type'(VAL_MIN)) return VAL_MIN;
      return a[63:0];
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint curve_at(longint q, int unsigned n);
      int unsigned below, above, mid, idx;
      bit hit;
      longint x0, x1, y0, y1, dx, dy, t;
      wide_type step;
      below = 0; above = n + 1; hit = 0; idx = 0;
      while (above - below > 1) begin
         mid = (above + below) / 2;
         if (q == xtab[mid-1]) begin
            idx = mid - 1;
            hit = 1;
            break;
         end
         if (q < xtab[mid-1]) above = mid;
         else below = mid;
      end
      if (!hit) idx = (below == 0) ? 0 : below - 1;
      if (idx > n - 2) idx = n - 2;
      x0 = xtab[idx]; x1 = xtab[idx+1];
      y0 = ytab[idx]; y1 = ytab[idx+1];
      dx = x1 - x0;
      if (dx == 0) return y0;
      dy = y1 - y0;
      t = q - x0;
      step = wide_type'(dy < 0 ? -dy : dy) * wide_type'(t < 0 ? -t : t)
             / wide_type'(dx < 0 ? -dx : dx);
      if (((dy < 0) != (t < 0)) != (dx < 0)) step = -step;
      return sat64(wide_type'(y0) + step);
   endfunction

   function automatic longint area_between(longint a, longint b, int unsigned n);
      bit flip, neg;
      longint tmp, fb, px, py, xi, yi;
      wide_type acc, m;
      flip = a > b;
      if (flip) begin
         tmp = a; a = b; b = tmp;
      end
      py = clamp32(curve_at(a, n));
      fb = clamp32(curve_at(b, n));
      px = a;
      acc = 0;
      for (int i = 0; i < n; i++) begin
         xi = xtab[i]; yi = ytab[i];
         if (a < xi && xi < b) begin
            acc = acc + wide_type'(py + yi) * wide_type'(xi - px);
            px = xi; py = yi;
         end
      end
      acc = acc + wide_type'(py + fb) * wide_type'(b - px);
      neg = acc < 0;
      m = neg ? -acc : acc;
      m = m >> (FRAC_BITS + 1);
      return sat64((neg != flip) ? -m : m);
   endfunction

   function automatic bit off_curve(longint v, int unsigned n);
      return v < xtab[0] || v > xtab[n-1];
   endfunction

   // applies one accepted request to the bench state and returns its result
   function automatic result_type expected_result(step_type s);
      result_type r;
      int unsigned n;
      n = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
      r.value = 0;
      r.status = STAT_OK;
      if (s.cmd == CMD_WRITE) begin
         xtab[s.idx] = s.px;
         ytab[s.idx] = s.py;
      end else if (s.cmd != CMD_NONE) begin
         if (n < 2) r.status = STAT_FEW;
         else if (s.cmd == CMD_INTERP) begin
            if (off_curve(s.qx, n)) r.status = STAT_RANGE;
            else r.value = curve_at(s.qx, n);
         end else begin
            if (off_curve(s.bl, n) || off_curve(s.bh, n)) r.status = STAT_RANGE;
            else if (s.bl != s.bh) r.value = area_between(s.bl, s.bh, n);
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      errors++;
   endtask

   task automatic send_request(step_type s);
      result_type r;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid = 0;
         end
      end
      @(negedge clock);
      req_cmd = s.cmd;
      req_point_index = s.idx;
      req_point_x = s.px;
      req_point_y = s.py;
      req_query_x = s.qx;
      req_bound_low = s.bl;
      req_bound_high = s.bh;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      sent_count++;
      r = expected_result(s);
      if (s.fixed) begin
         r.value = s.value;
         r.status = s.status;
      end
      pending_results = {pending_results, r};
   endtask

   // drop valid and wait for every outstanding result
   task automatic drain;
      if (req_valid) begin
         @(negedge clock);
         req_valid = 0;
      end
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_count(logic [10:0] n);
      drain();
      @(negedge clock);
      csr_point_count = n;
      csr_valid = 1;
      do @(posedge clock); while (!csr_ready);
      point_count = n;
      @(negedge clock);
      csr_valid = 0;
   endtask

   // random Q16.16 abscissa: mostly inside the table span, some on a point,
   // the rest anywhere
   function automatic logic signed [31:0] pick_x(int unsigned n);
      longint lo, span;
      logic [63:0] r;
      int sel;
      sel = $urandom_range(0, 9);
      if (n < 2 || sel >= 8) return $urandom;
      if (sel == 7) return xtab[$urandom_range(0, n - 1)];
      lo = xtab[0];
      span = longint'(xtab[n-1]) - lo;
      if (span <= 0) return xtab[0];
      r = {$urandom, $urandom};
      return lo + longint'(r % (span + 1));
   endfunction

   function automatic step_type blank_step();
      step_type s;
      s = '0;
      s.px = $urandom; s.py = $urandom; s.qx = $urandom;
      s.bl = $urandom; s.bh = $urandom; s.idx = $urandom;
      return s;
   endfunction

   // fill slots 0..n-1; style 0 ascending, 1 spanning the full range, 2 unordered
   task automatic load_curve(int n, int style);
      step_type s;
      longint x;
      x = longint'($urandom_range(0, 1 << 21)) - (1 << 20);
      for (int i = 0; i < n; i++) begin
         s = blank_step();
         s.cmd = CMD_WRITE;
         s.idx = i;
         case (style)
            0: begin
               if ($urandom_range(0, 9) != 0) x += $urandom_range(1, 1 << 20);
               s.px = x;
            end
            1: s.px = (n == 1) ? 32'sh8000_0000 :
                      -64'sd2147483648 + (longint'(i) * 64'd4294967295) / (n - 1);
            default: s.px = $urandom;
         endcase
         if ($urandom_range(0, 1)) s.py = $signed($urandom_range(0, 1 << 24)) - (1 << 23);
         send_request(s);
      end
   endtask

   task automatic query_burst(int count, int unsigned n);
      step_type s;
      int sel;
      for (int k = 0; k < count; k++) begin
         s = blank_step();
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            s.cmd = CMD_INTERP;
            s.qx = pick_x(n);
         end else if (sel < 88) begin
            s.cmd = CMD_INTEG;
            s.bl = pick_x(n);
            s.bh = ($urandom_range(0, 19) == 0) ? s.bl : pick_x(n);
         end else if (sel < 93 && n >= 1) begin
            // rewrite a slot in use; can leave the table out of order
            s.cmd = CMD_WRITE;
            s.idx = $urandom_range(0, n - 1);
         end else s.cmd = CMD_NONE;
         send_request(s);
      end
   endtask

   step_type directed_steps [24] = '{
      '{0, 0, CMD_INTERP, 0, 0, 0, 0, 0, 0, 1, 0, STAT_FEW},
      '{0, 0, CMD_INTEG, 0, 0, 0, 0, 0, 5 * ONE, 1, 0, STAT_FEW},
      '{0, 0, CMD_NONE, 7, 3, 4, 5, 6, 7, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 0, -100 * ONE, 5 * ONE, 0, 0, 0, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 1, 0, -3 * ONE, 0, 0, 0, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 2, 0, 7 * ONE, 0, 0, 0, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 3, 50 * ONE, 32'sh7fff_ffff, 0, 0, 0, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 4, 60 * ONE, 32'sh8000_0000, 0, 0, 0, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 5, 32'sh7fff_ffff, -1, 0, 0, 0, 1, 0, STAT_OK},
      '{0, 0, CMD_WRITE, 1023, -1, 32'sh7fff_ffff, 0, 0, 0, 1, 0, STAT_OK},
      '{1, 1, CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, 0, 0, 0, 1, 0, STAT_FEW},
      '{1, 6, CMD_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, -100 * ONE, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, 0, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, 25 * ONE, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, 55 * ONE, 0, 0, 0, 0, STAT_OK},
      '{0, 0, CMD_INTERP, 0, 0, 0, 32'sh8000_0000, 0, 0, 1, 0, STAT_RANGE},
      '{0, 0, CMD_INTEG, 0, 0, 0, 0, 10 * ONE, 10 * ONE, 1, 0, STAT_OK},
      '{0, 0, CMD_INTEG, 0, 0, 0, 0, -100 * ONE, 32'sh7fff_ffff, 0, 0, STAT_OK},
      '{0, 0, CMD_INTEG, 0, 0, 0, 0, 32'sh7fff_ffff, -100 * ONE, 0, 0, STAT_OK},
      '{0, 0, CMD_INTEG, 0, 0, 0, 0, -50 * ONE, -101 * ONE, 1, 0, STAT_RANGE},
      '{0, 0, CMD_INTEG, 0, 0, 0, 0, 0, 55 * ONE, 0, 0, STAT_OK}
   };

   // response checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("ERROR at %0t: response with nothing outstanding", $realtime);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            checked_count++;
         end
      end
   end

   // receiver: stall modes change now and then; one long hold-off to back up the block
   initial begin
      int mode_left, mode, hold;
      bit held_long;
      mode_left = 0; mode = 0; hold = 0; held_long = 0;
      forever begin
         @(negedge clock);
         if (!held_long && sent_count >= 300) begin
            held_long = 1;
            hold = 400;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(20, 200);
            mode = $urandom_range(0, 2);
         end
         mode_left--;
         if (hold > 0) begin
            hold--;
            rsp_ready = 0;
         end else case (mode)
            0: rsp_ready = 1;
            1: rsp_ready = $urandom_range(0, 1);
            default: rsp_ready = ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > RUN_LIMIT) begin
         $display("sampled_curve_interp_integrate: mismatch");
         $finish;
      end
   end

   initial begin
      int queries, n, style;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].is_cfg) write_count(directed_steps[i].count);
         else send_request(directed_steps[i]);
      end

      // small tables with random contents; the extremes of the count come up too
      queries = 0;
      n = 2;
      while (queries < 600) begin
         style = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
         load_curve(n, style);
         write_count(n);
         query_burst(30, n);
         queries += 30;
         if ($urandom_range(0, 5) == 0) begin
            write_count($urandom_range(0, 1));
            query_burst(4, 0);
         end
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 16);
      end

      // full table, count at and above the depth
      load_curve(TABLE_DEPTH, 0);
      write_count(11'd2047);
      query_burst(8, TABLE_DEPTH);
      write_count(TABLE_DEPTH);
      query_burst(8, TABLE_DEPTH);

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d requests, %0d responses checked, counts 0 to 2047",
               sent_count, checked_count);
      $display("tables ascending, full-range and unordered; interpolate and integrate");
      if (errors == 0 && pending_results.size() == 0)
         $display("sampled_curve_interp_integrate: match");
      else
         $display("sampled_curve_interp_integrate: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
+incdir+design
design/scit_pkg.sv
design/scit_mem.sv
design/scit_mul.sv
design/scit_div.sv
design/sampled_curve_interp_integrate.sv
design/scit_checker.sv
bench/tb.sv
